>>> rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VALUE = 1'b0,
        CFG_MIN_VALUE = 1'b1
    } t_cfg_idx;

endpackage

>>> rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue: heap memory, sift sequencer and limit registers.
//
//  channel   | signals                                         | transfer
//  ----------+-------------------------------------------------+-------------------------
//  command   | start, busy, i_func, i_value                    | start high, busy low
//  result    | o_valid, o_status, o_removed_value, o_top_value,| o_valid high, one cycle
//            | o_count                                         |
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data                 | i_cfg_we high
//
// A rejected command (full, empty, out of range) or an insert into an empty heap
// finishes in the cycle of its transfer; the result shows in the next cycle.
// An insert sifts up one level per cycle, plus the root write. A remove loads root
// and last entry, walks down one level per cycle and may end with one write.
// Reset empties the heap at once, memory is not cleared; results cannot be stalled.
module max_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_func,
    input  logic signed [mhpq_pkg::VALUE_W-1:0]    i_value,
    input  logic                                   i_cfg_we,
    input  logic [mhpq_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mhpq_pkg::VALUE_W-1:0]           i_cfg_data,
    output logic                                   o_valid,
    output logic [1:0]                             o_status,
    output logic signed [mhpq_pkg::VALUE_W-1:0]    o_removed_value,
    output logic signed [mhpq_pkg::VALUE_W-1:0]    o_top_value,
    output logic [mhpq_pkg::COUNT_W-1:0]           o_count
);

    localparam int SW = $clog2(CAPACITY + 1);   // slot number 1..CAPACITY
    localparam int CW = SW + 1;                 // child slot may pass the end
    localparam int AW = $clog2(CAPACITY);       // memory address = slot - 1
    localparam int VW = mhpq_pkg::VALUE_W;
    localparam int OCW = mhpq_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN_LD,
        S_DN_CMP,
        S_FIN
    } t_state;

    // heap memory: one write port, two registered read ports
    logic signed [VW-1:0] mem [CAPACITY];
    logic signed [VW-1:0] r_rd_a;
    logic signed [VW-1:0] r_rd_b;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [VW-1:0] mem_wdata;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;

    t_state               r_state, n_state;
    logic [SW-1:0]        r_count, n_count;
    logic [SW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_c, n_c;
    logic signed [VW-1:0] r_val, n_val;
    logic signed [VW-1:0] r_removed, n_removed;
    logic signed [VW-1:0] r_top, n_top;
    logic signed [VW-1:0] r_max, r_min;
    logic                 r_valid, n_valid;
    mhpq_pkg::t_status    r_status, n_status;
    logic signed [VW-1:0] r_o_removed, n_o_removed;
    logic signed [VW-1:0] r_o_top, n_o_top;
    logic [OCW-1:0]       r_o_count, n_o_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    always_comb begin
        logic                 done;
        mhpq_pkg::t_status    st;
        logic                 take_b;
        logic signed [VW-1:0] child_v;
        logic [CW-1:0]        child_s;
        logic [CW-1:0]        next_c;
        logic [SW-1:0]        up_i;

        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_c       = r_c;
        n_val     = r_val;
        n_removed = r_removed;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_val;
        rd_en     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        done      = 1'b0;
        st        = mhpq_pkg::ST_OK;
        take_b    = 1'b0;
        child_v   = r_rd_a;
        child_s   = r_c;
        next_c    = '0;
        up_i      = r_i >> 1;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_removed = '0;
                    if (i_func == mhpq_pkg::FUNC_INSERT) begin
                        if (r_count == SW'(CAPACITY)) begin
                            done = 1'b1;
                            st   = mhpq_pkg::ST_FULL;
                        end else if (i_value > r_max || i_value < r_min) begin
                            done = 1'b1;
                            st   = mhpq_pkg::ST_RANGE;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = i_value;
                            n_count   = SW'(1);
                            done      = 1'b1;
                        end else begin
                            n_val     = i_value;
                            n_i       = r_count + SW'(1);
                            rd_en     = 1'b1;
                            rd_addr_a = AW'(((r_count + SW'(1)) >> 1) - SW'(1));
                            n_state   = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            done = 1'b1;
                            st   = mhpq_pkg::ST_EMPTY;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr_a = '0;
                            rd_addr_b = AW'(r_count - SW'(1));
                            n_state   = S_DN_LD;
                        end
                    end
                end
            end

            S_UP: begin
                // r_rd_a holds the parent of slot r_i
                if (r_val > r_rd_a) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_i - SW'(1));
                    mem_wdata = r_rd_a;
                    n_i       = up_i;
                    if (up_i == SW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr_a = AW'((up_i >> 1) - SW'(1));
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_i - SW'(1));
                    n_count   = r_count + SW'(1);
                    done      = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_DN_LD: begin
                // root on port a, last entry on port b
                n_removed = r_rd_a;
                n_val     = r_rd_b;
                n_count   = r_count - SW'(1);
                n_i       = SW'(1);
                n_c       = CW'(2);
                if (r_count == SW'(1)) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else if (r_count == SW'(2)) begin
                    n_state = S_FIN;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr_a = AW'(1);
                    rd_addr_b = AW'(2);
                    n_state   = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                // ties keep the left child
                take_b  = (r_c < {1'b0, r_count}) && (r_rd_a < r_rd_b);
                child_v = take_b ? r_rd_b : r_rd_a;
                child_s = r_c + CW'(take_b);
                next_c  = child_s << 1;
                if (r_val >= child_v) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_i - SW'(1));
                    done      = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_i - SW'(1));
                    mem_wdata = child_v;
                    n_i       = SW'(child_s);
                    n_c       = next_c;
                    if (next_c <= {1'b0, r_count}) begin
                        rd_en     = 1'b1;
                        rd_addr_a = AW'(next_c - CW'(1));
                        rd_addr_b = AW'(next_c);
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_i - SW'(1));
                done      = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // count also grows when the final write of an insert lands in FIN
        if (r_state == S_FIN && r_c == '0) begin
            n_count = r_count + SW'(1);
        end

        n_top = (mem_we && mem_waddr == '0) ? mem_wdata : r_top;

        n_valid     = done;
        n_status    = r_status;
        n_o_removed = r_o_removed;
        n_o_top     = r_o_top;
        n_o_count   = r_o_count;
        if (done) begin
            n_status    = st;
            n_o_removed = (st == mhpq_pkg::ST_OK) ? n_removed : '0;
            n_o_top     = (n_count != '0) ? n_top : '0;
            n_o_count   = OCW'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_max     <= 32'sh7FFF_FFFF;
            r_min     <= 32'sh8000_0000;
            r_c       <= '0;
            r_status  <= mhpq_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_status <= n_status;
            // a command clears the child slot and removes set it again, which marks inserts in FIN
            if (r_state == S_IDLE && start) begin
                r_c <= '0;
            end else begin
                r_c <= n_c;
            end
            if (i_cfg_we) begin
                unique case (mhpq_pkg::t_cfg_idx'(i_cfg_idx))
                    mhpq_pkg::CFG_MAX_VALUE: r_max <= i_cfg_data;
                    mhpq_pkg::CFG_MIN_VALUE: r_min <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_i         <= n_i;
        r_val       <= n_val;
        r_removed   <= n_removed;
        r_top       <= n_top;
        r_o_removed <= n_o_removed;
        r_o_top     <= n_o_top;
        r_o_count   <= n_o_count;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_o_removed;
    assign o_top_value     = r_o_top;
    assign o_count         = r_o_count;

endmodule

>>> rtl/mhpq_checker.sv
// Port-level assertions for the max-heap priority queue, bound to the top level.
module mhpq_port_props (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [1:0]                          o_status,
    input logic signed [mhpq_pkg::VALUE_W-1:0] o_removed_value,
    input logic signed [mhpq_pkg::VALUE_W-1:0] o_top_value,
    input logic [mhpq_pkg::COUNT_W-1:0]        o_count
);

    // a result only ever shows once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // every transfer either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("command transfer lost");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count == '0) |-> (o_top_value == '0))
        else $error("empty heap reports a top value");

    a_fail_no_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != mhpq_pkg::ST_OK) |-> (o_removed_value == '0))
        else $error("failed command reports a removed value");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mhpq_pkg::ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with non-zero count");

endmodule

bind max_heap_priority_queue mhpq_port_props u_mhpq_port_props (.*);

>>> tb/mhpq_checker.sv
`timescale 1ns / 1ps
// Result checker for the max-heap queue: tracks commands and limits, predicts and compares.
module mhpq_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic                                i_func,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_cfg_we,
    input  logic [mhpq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mhpq_pkg::VALUE_W-1:0]        i_cfg_data,
    input  logic                                i_valid,
    input  logic [1:0]                          i_status,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_removed_value,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_top_value,
    input  logic [mhpq_pkg::COUNT_W-1:0]        i_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int VW  = mhpq_pkg::VALUE_W;
    localparam int OCW = mhpq_pkg::COUNT_W;

    typedef struct packed {
        mhpq_pkg::t_status    status;
        logic signed [VW-1:0] removed;
        logic signed [VW-1:0] peak;
        logic [OCW-1:0]       count;
    } t_heap_result;

    int           heap_mem [1:CAPACITY];
    int           heap_fill;
    int           max_lim;
    int           min_lim;
    t_heap_result expected_q [$];
    int           fails = 0;

    // One command against the local heap copy; returns what the block should report.
    function automatic t_heap_result heap_apply(input mhpq_pkg::t_func op, input int v);
        t_heap_result r;
        int idx;
        int child;
        int tail_val;
        r.status  = mhpq_pkg::ST_OK;
        r.removed = '0;
        if (op == mhpq_pkg::FUNC_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                r.status = mhpq_pkg::ST_FULL;
            end else if (v > max_lim || v < min_lim) begin
                r.status = mhpq_pkg::ST_RANGE;
            end else begin
                idx = heap_fill + 1;
                while (idx > 1 && v > heap_mem[idx / 2]) begin
                    heap_mem[idx] = heap_mem[idx / 2];
                    idx = idx / 2;
                end
                heap_mem[idx] = v;
                heap_fill++;
            end
        end else if (heap_fill == 0) begin
            r.status = mhpq_pkg::ST_EMPTY;
        end else begin
            r.removed = heap_mem[1];
            tail_val  = heap_mem[heap_fill];
            heap_fill--;
            idx   = 1;
            child = 2;
            // ties go left; stop once the moved element is at least the larger child
            while (child <= heap_fill) begin
                if (child < heap_fill && heap_mem[child] < heap_mem[child + 1])
                    child++;
                if (tail_val >= heap_mem[child])
                    break;
                heap_mem[idx] = heap_mem[child];
                idx   = child;
                child = child * 2;
            end
            if (heap_fill > 0)
                heap_mem[idx] = tail_val;
        end
        r.peak  = (heap_fill > 0) ? heap_mem[1] : 0;
        r.count = OCW'(heap_fill);
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_heap_result want;
        if (!i_rst_n) begin
            heap_fill = 0;
            max_lim   = 32'sh7fffffff;
            min_lim   = 32'sh80000000;
            expected_q.delete();
        end else begin
            // results first, so a stray strobe is never matched to this edge's command
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing outstanding, expected none, got status %0d count %0d",
                             $time, i_status, i_count);
                end else begin
                    want = expected_q.pop_front();
                    if (i_status !== want.status)
                        flag_mismatch("status", want.status, i_status);
                    if (i_removed_value !== want.removed)
                        flag_mismatch("removed_value", want.removed, i_removed_value);
                    if (i_top_value !== want.peak)
                        flag_mismatch("top_value", want.peak, i_top_value);
                    if (i_count !== want.count)
                        flag_mismatch("count", want.count, i_count);
                end
            end
            if (i_cfg_we) begin
                case (mhpq_pkg::t_cfg_idx'(i_cfg_idx))
                    mhpq_pkg::CFG_MAX_VALUE: max_lim = $signed(i_cfg_data);
                    mhpq_pkg::CFG_MIN_VALUE: min_lim = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_q.push_back(heap_apply(mhpq_pkg::t_func'(i_func), i_value));
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the max-heap queue: clock, reset, command and limit stimulus, verdict.
module tb;

    localparam int CAPACITY    = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int RUN_LEN     = 68;
    localparam int VW          = mhpq_pkg::VALUE_W;
    localparam logic signed [VW-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [VW-1:0] VMIN = 32'sh80000000;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic                                  i_func;
    logic signed [VW-1:0]                  i_value;
    logic                                  i_cfg_we;
    logic [mhpq_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [VW-1:0]                         i_cfg_data;
    logic                                  o_valid;
    logic [1:0]                            o_status;
    logic signed [VW-1:0]                  o_removed_value;
    logic signed [VW-1:0]                  o_top_value;
    logic [mhpq_pkg::COUNT_W-1:0]          o_count;
    int                                    fail_count;
    int                                    pending;
    int                                    stall_cycles = 0;
    logic signed [VW-1:0]                  rand_a;
    logic signed [VW-1:0]                  rand_b;

    max_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_value(i_value),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_status(o_status), .o_removed_value(o_removed_value),
        .o_top_value(o_top_value), .o_count(o_count)
    );

    mhpq_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_value(i_value),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_status(o_status), .i_removed_value(o_removed_value),
        .i_top_value(o_top_value), .i_count(o_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: too long without any command or result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Holds the command until it is taken; start stays high when no gap follows.
    task automatic issue(input mhpq_pkg::t_func op, input logic signed [VW-1:0] v,
                         input int gap);
        start   <= 1'b1;
        i_func  <= op;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Limits only change with the queue drained and idle.
    task automatic set_limits(input logic signed [VW-1:0] hi,
                              input logic signed [VW-1:0] lo);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mhpq_pkg::CFG_MAX_VALUE;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= mhpq_pkg::CFG_MIN_VALUE;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly legal values, with limit edges, just-outside values and a tight pool for ties.
    function automatic logic signed [VW-1:0] pick_value(
            input logic signed [VW-1:0] hi, input logic signed [VW-1:0] lo);
        longint span;
        int     r;
        span = longint'(hi) - longint'(lo);
        r    = $urandom_range(0, 99);
        if (span < 0 || r < 6)
            return $urandom;
        if (r < 10)
            return (hi == VMAX) ? $urandom : hi + 1;
        if (r < 14)
            return (lo == VMIN) ? $urandom : lo - 1;
        if (r < 20)
            return hi;
        if (r < 26)
            return lo;
        if (r < 40)
            return (span < 3) ? lo : lo + $urandom_range(0, 3);
        return VW'(longint'(lo) + longint'({32'b0, $urandom} % (span + 1)));
    endfunction

    task automatic run_phase(input logic signed [VW-1:0] hi,
                             input logic signed [VW-1:0] lo,
                             input int n_items, input bit idle_ok);
        int done;
        int seg_len;
        int ins_pct;
        int gap;
        bit idle_on;
        set_limits(hi, lo);
        done    = 0;
        // open with a straight run of inserts so the full case can be reached
        seg_len = RUN_LEN;
        ins_pct = 100;
        while (done < n_items) begin
            idle_on = idle_ok && ($urandom_range(0, 2) != 0);
            repeat (seg_len) begin
                if (done >= n_items)
                    break;
                gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                issue(($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::FUNC_INSERT
                                                         : mhpq_pkg::FUNC_REMOVE,
                      pick_value(hi, lo), gap);
                done++;
            end
            case ($urandom_range(0, 2))
                0: begin
                    seg_len = 70;
                    ins_pct = 90;
                end
                1: begin
                    seg_len = 70;
                    ins_pct = 10;
                end
                default: begin
                    seg_len = 30;
                    ins_pct = 50;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_func     <= mhpq_pkg::FUNC_INSERT;
        i_value    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= mhpq_pkg::CFG_MAX_VALUE;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, extremes, ties, then range limits
        issue(mhpq_pkg::FUNC_REMOVE, 0, 0);
        issue(mhpq_pkg::FUNC_INSERT, VMIN, 0);
        issue(mhpq_pkg::FUNC_INSERT, VMAX, 1);
        issue(mhpq_pkg::FUNC_INSERT, 0, 0);
        issue(mhpq_pkg::FUNC_INSERT, -1, 0);
        issue(mhpq_pkg::FUNC_INSERT, 5, 0);
        issue(mhpq_pkg::FUNC_INSERT, 5, 2);
        issue(mhpq_pkg::FUNC_INSERT, 5, 0);
        repeat (5) issue(mhpq_pkg::FUNC_REMOVE, $urandom, 0);
        set_limits(100, -100);
        issue(mhpq_pkg::FUNC_INSERT, 101, 0);
        issue(mhpq_pkg::FUNC_INSERT, -101, 0);
        issue(mhpq_pkg::FUNC_INSERT, 100, 0);
        issue(mhpq_pkg::FUNC_INSERT, -100, 0);
        repeat (4) issue(mhpq_pkg::FUNC_REMOVE, 0, 0);
        // inverted limits reject every insert
        set_limits(-10, 10);
        issue(mhpq_pkg::FUNC_INSERT, 0, 0);
        issue(mhpq_pkg::FUNC_INSERT, 10, 0);

        run_phase(VMAX, VMIN, 220, 1'b1);
        run_phase(1000, -1000, 220, 1'b1);
        run_phase(VMAX, VMAX, 220, 1'b1);
        run_phase(VMIN, VMIN, 220, 1'b1);
        run_phase(-5, 5, 60, 1'b1);
        rand_a = $urandom;
        rand_b = $urandom;
        if (rand_a >= rand_b)
            run_phase(rand_a, rand_b, 220, 1'b1);
        else
            run_phase(rand_b, rand_a, 220, 1'b1);
        run_phase(0, VMIN, 220, 1'b1);
        run_phase(VMAX, VMIN, 220, 1'b0);

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
